// File: sv/lrupr_pkg.sv
// Package for the LRU page replacement list: payload structs, opcodes,
// status codes and the cell command struct.
// No dependencies.
package lrupr_pkg;

   // Page identifier width, used by the payload fields.
   localparam int PAGE_BITS = 20;
   localparam int STATUS_BITS = 2;
   localparam int DEPTH_DEFAULT = 16;

   // Opcodes
   localparam logic OP_TOUCH = 1'b0;
   localparam logic OP_EVICT = 1'b1;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                 opcode;
      logic [PAGE_BITS-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0]   victim_page;
      logic [STATUS_BITS-1:0] status;
      logic                   was_present;
   } rsp_type;

   // Command broadcast to every cell of the list
   typedef struct packed {
      logic                 go;
      logic                 opcode;
      logic [PAGE_BITS-1:0] page;
      logic                 found;
   } cell_cmd_type;

endpackage

// File: sv/lrupr_cell.sv
// One slot of the recency list: holds a page id and a valid bit, compares
// against the broadcast page and shifts toward the oldest end on command.
// Depends on lrupr_pkg.
module lrupr_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lrupr_pkg::cell_cmd_type        cmd,
   input  logic                           hit_in,
   input  logic                           prev_valid,
   input  logic                           next_valid,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] next_slot,
   output logic                           hit_out,
   output logic                           valid,
   output logic [lrupr_pkg::PAGE_BITS-1:0] slot
);
   import lrupr_pkg::*;

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] slot_ff, slot_in;
   logic                 match;

   // Compare and hit chain: hit_out is high from the matching cell upward
   assign match   = (cmd.opcode == OP_TOUCH) && valid_ff && (slot_ff == cmd.page);
   assign hit_out = hit_in | match;

   // Next slot contents
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (cmd.go) begin
         if (cmd.opcode == OP_EVICT) begin
            // everything moves one place toward the oldest end
            slot_in  = next_slot;
            valid_in = next_valid;
         end else if (cmd.found) begin
            // close the gap above the hit, re-insert at the tail
            if (hit_out) begin
               if (valid_ff && !next_valid) begin
                  slot_in = cmd.page;
               end else begin
                  slot_in = next_slot;
               end
            end
         end else if (!valid_ff && prev_valid) begin
            // first free slot takes the new page; none exists when full
            slot_in  = cmd.page;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign valid = valid_ff;
   assign slot  = slot_ff;

endmodule

// File: sv/lru_page_replacement_list_unit.sv
// Top level of the LRU page replacement list: a chain of lrupr_cell slots,
// result computation and a two-entry output register with skid stage.
// Depends on lrupr_pkg and lrupr_cell.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one transaction per
//   access: opcode touch moves or appends page_id at the most recent end,
//   opcode evict removes and returns the least recently used page.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one result
//   per request, in order.
//   Each result is registered in the output register, or in the skid stage.
//   Throughput: one transaction per cycle while req_stall is low. All slots
//   compare in parallel and the hit flag ripples through the cell chain in the
//   same cycle, so the clock period is set by that DEPTH-long ripple.
//   When rsp is stalled, the skid stage takes one more result; req_stall then
//   rises until the receiver drains the output register.
//   Reset (synchronous, active high) empties the list and both output stages.
//   An evict on an empty list returns status EMPTY; a touch of a new page on
//   a full list is dropped with status FULL.
module lru_page_replacement_list_unit #(
   parameter int DEPTH = lrupr_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lrupr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lrupr_pkg::rsp_type rsp_data
);
   import lrupr_pkg::*;

   logic [PAGE_BITS-1:0] slot_w [DEPTH];
   logic [DEPTH-1:0]     valid_w;
   logic [DEPTH:0]       hit_w;
   logic [DEPTH+1:0]     valid_ext;   // valid bits with end guards
   cell_cmd_type         cmd;
   logic                 accept;
   logic                 found;
   rsp_type              result;

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    out_pop;

   assign accept = req_valid && !req_stall;
   assign found  = hit_w[DEPTH];

   // Broadcast command
   always_comb begin
      cmd.go     = accept;
      cmd.opcode = req_data.opcode;
      cmd.page   = req_data.page_id;
      cmd.found  = found;
   end

   // Guards: below cell 0 counts as valid, above the last cell as empty
   assign valid_ext = {1'b0, valid_w, 1'b1};
   assign hit_w[0]  = 1'b0;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PAGE_BITS-1:0] next_slot;
      if (i == DEPTH - 1) begin : g_last
         assign next_slot = '0;
      end else begin : g_mid
         assign next_slot = slot_w[i+1];
      end
      lrupr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .hit_in     (hit_w[i]),
         .prev_valid (valid_ext[i]),
         .next_valid (valid_ext[i+2]),
         .next_slot  (next_slot),
         .hit_out    (hit_w[i+1]),
         .valid      (valid_w[i]),
         .slot       (slot_w[i])
      );
   end

   // Result of the current transaction
   always_comb begin
      result.victim_page = '0;
      result.status      = STATUS_OK;
      result.was_present = 1'b0;
      if (req_data.opcode == OP_EVICT) begin
         if (valid_w[0]) begin
            result.victim_page = slot_w[0];
         end else begin
            result.status = STATUS_EMPTY;
         end
      end else if (found) begin
         result.was_present = 1'b1;
      end else if (valid_w[DEPTH-1]) begin
         result.status = STATUS_FULL;
      end
   end

   // Output register with skid stage
   assign out_pop = main_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!main_valid_ff || out_pop) begin
            if (skid_valid_ff) begin
               main_valid_ff <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               main_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (accept) begin
            main_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

// File: tb/tb_top.sv
// Testbench for lru_page_replacement_list_unit: directed table, then random access phases,
// each result checked against its typed value or an in-bench move-to-front recency list.
// Depends on lrupr_pkg and the RTL of lru_page_replacement_list_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lrupr_pkg::*;

   localparam int TB_DEPTH   = DEPTH_DEFAULT;
   localparam int POOL_SIZE  = 24;
   localparam int NUM_PHASES = 9;
   localparam int PHASE_LEN  = 95;
   localparam int DIR_ROWS   = 24;
   localparam int DRAIN_MAX  = 20000;

   // One directed transaction: the request, and the result typed in when known at a glance
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{'{OP_EVICT, 20'hFFFFF}, 1'b1, '{20'h00000, STATUS_EMPTY, 1'b0}}, // evict, empty list
      '{'{OP_TOUCH, 20'h00000}, 1'b1, '{20'h00000, STATUS_OK,    1'b0}},
      '{'{OP_TOUCH, 20'hFFFFF}, 1'b1, '{20'h00000, STATUS_OK,    1'b0}},
      '{'{OP_TOUCH, 20'h00000}, 1'b1, '{20'h00000, STATUS_OK,    1'b1}}, // hit, moves to MRU
      '{'{OP_EVICT, 20'h12345}, 1'b1, '{20'hFFFFF, STATUS_OK,    1'b0}},
      // fill up to DEPTH entries
      '{'{OP_TOUCH, 20'h80000}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h7FFFF}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h55555}, 1'b0, '0},
      '{'{OP_TOUCH, 20'hAAAAA}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h00001}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h12345}, 1'b0, '0},
      '{'{OP_TOUCH, 20'hFEDCB}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h0F0F0}, 1'b0, '0},
      '{'{OP_TOUCH, 20'hF0F0F}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h33333}, 1'b0, '0},
      '{'{OP_TOUCH, 20'hCCCCC}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h00100}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h40000}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h00010}, 1'b0, '0},
      '{'{OP_TOUCH, 20'hFFFFE}, 1'b0, '0},
      '{'{OP_TOUCH, 20'h99999}, 1'b1, '{20'h00000, STATUS_FULL,  1'b0}}, // new page, full list
      '{'{OP_TOUCH, 20'h55555}, 1'b0, '0},                               // hit in the middle
      '{'{OP_TOUCH, 20'h00000}, 1'b0, '0},                               // hit on LRU, full
      '{'{OP_EVICT, 20'hFFFFF}, 1'b0, '0}
   };

   // Evict share per random phase, in percent
   localparam int EVICT_PCT [NUM_PHASES] = '{5, 20, 35, 50, 65, 10, 40, 80, 25};

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Recency list as the bench sees it, oldest first
   logic [PAGE_BITS-1:0] lru_list [$];
   rsp_type              pending_rsp_q [$];
   logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];
   int unsigned          mismatch_count = 0;
   bit                   quiet = 1'b0;

   lru_page_replacement_list_unit #(
      .DEPTH(TB_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Length of an idle stretch: mostly short, now and then long
   function automatic int unsigned span_len();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Apply one access to the recency list and return the result it gives
   function automatic rsp_type apply_access(input req_type item);
      rsp_type res;
      int      hit_pos;
      res = '0;
      hit_pos = -1;
      if (item.opcode == OP_EVICT) begin
         if (lru_list.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.victim_page = lru_list.pop_front();
         end
      end else begin
         foreach (lru_list[i]) begin
            if (hit_pos < 0 && lru_list[i] == item.page_id) hit_pos = i;
         end
         if (hit_pos >= 0) begin
            res.was_present = 1'b1;
            lru_list.delete(hit_pos);
            lru_list.push_back(item.page_id);
         end else if (lru_list.size() >= TB_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            lru_list.push_back(item.page_id);
         end
      end
      return res;
   endfunction

   // Drive one transaction from the falling edge, wait for acceptance, log the expected result
   task automatic send_access(input req_type item, input logic typed, input rsp_type want);
      int unsigned gap;
      rsp_type     pred;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 30) gap = span_len();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      pred = apply_access(item);
      pending_rsp_q.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding result has come back
   task automatic wait_all_results();
      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver back-pressure
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
            if (!quiet && $urandom_range(0, 99) < 20) hold_left = span_len();
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected result transaction: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.victim_page !== want.victim_page) begin
               $error("victim_page: expected %h, got %h", want.victim_page,
                      rsp_data.victim_page);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.was_present !== want.was_present) begin
               $error("was_present: expected %b, got %b", want.was_present,
                      rsp_data.was_present);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      req_type     item;
      int unsigned drain_cycles;
      foreach (page_pool[i]) page_pool[i] = PAGE_BITS'($urandom());
      page_pool[0] = 20'h00000;
      page_pool[1] = 20'hFFFFF;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIR_TABLE[r]) begin
         send_access(DIR_TABLE[r].item, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end

      // Random phases: small pool so hits and full-list drops are frequent
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiet = (ph == 2 || ph == 5);
         for (int k = 0; k < 8; k++) begin
            page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_BITS'($urandom());
         end
         for (int n = 0; n < PHASE_LEN; n++) begin
            item.opcode = ($urandom_range(0, 99) < EVICT_PCT[ph]) ? OP_EVICT : OP_TOUCH;
            if ($urandom_range(0, 99) < 80) begin
               item.page_id = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
               item.page_id = PAGE_BITS'($urandom());
            end
            send_access(item, 1'b0, '0);
         end
         if (ph % 2 == 1) wait_all_results();
      end
      quiet = 1'b0;
      req_valid = 1'b0;

      // Drain
      drain_cycles = 0;
      while (pending_rsp_q.size() != 0 && drain_cycles < DRAIN_MAX) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_rsp_q.size() != 0) begin
         $display("end of test: mismatches");
      end else begin
         repeat (10) @(posedge clock);
         if (mismatch_count == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
